@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int SPQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int PRIO_W    = 16;
  localparam int CNT_W     = $clog2(SPQ_DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic [DATA_W-1:0]        item_data;
    logic signed [PRIO_W-1:0] item_priority;
  } in_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [DATA_W-1:0]        out_data;
    logic signed [PRIO_W-1:0] out_priority;
    logic [CNT_W-1:0]         entry_count;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       enq;
    logic       deq;
    logic [1:0] status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/spq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             operation,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire spq_pkg::dp_sts_t sts,
  output spq_pkg::dp_cmd_t      cmd
);
  import spq_pkg::*;

  localparam logic ST_OUT_EMPTY = 1'b0;
  localparam logic ST_OUT_HELD  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // a new request may enter unless a held result is stalled this cycle
  assign in_stall  = (state_r == ST_OUT_HELD) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_OUT_HELD);

  always_comb begin
    cmd.load   = accept;
    cmd.enq    = 1'b0;
    cmd.deq    = 1'b0;
    cmd.status = STATUS_OK;
    if (accept) begin
      case (operation)
        OP_ENQ: begin
          if (sts.full) begin
            cmd.status = STATUS_FULL;
          end else begin
            cmd.enq = 1'b1;
          end
        end
        OP_DEQ: begin
          if (sts.empty) begin
            cmd.status = STATUS_EMPTY;
          end else begin
            cmd.deq = 1'b1;
          end
        end
        default: begin
          cmd.status = STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_OUT_EMPTY: begin
        if (accept) begin
          state_nxt = ST_OUT_HELD;
        end
      end
      ST_OUT_HELD: begin
        if (accept) begin
          state_nxt = ST_OUT_HELD;
        end else if (!out_stall) begin
          state_nxt = ST_OUT_EMPTY;
        end
      end
      default: state_nxt = ST_OUT_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_OUT_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module spq_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [spq_pkg::DATA_W-1:0]       item_data,
  input  wire logic signed [spq_pkg::PRIO_W-1:0] item_priority,
  input  wire spq_pkg::dp_cmd_t                 cmd,
  output spq_pkg::dp_sts_t                      sts,
  output spq_pkg::out_rsp_t                     rsp
);
  import spq_pkg::*;

  logic [DATA_W-1:0]        data_r   [SPQ_DEPTH];
  logic [DATA_W-1:0]        data_nxt [SPQ_DEPTH];
  logic signed [PRIO_W-1:0] prio_r   [SPQ_DEPTH];
  logic signed [PRIO_W-1:0] prio_nxt [SPQ_DEPTH];
  logic [SPQ_DEPTH-1:0]     keep;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  out_rsp_t                 rsp_r;
  out_rsp_t                 rsp_nxt;

  assign sts.full  = (count_r == CNT_W'(SPQ_DEPTH));
  assign sts.empty = (count_r == '0);
  assign rsp       = rsp_r;

  // cells at or above a held entry of equal or higher priority stay put;
  // since the chain is sorted this is a prefix of cells
  always_comb begin
    for (int i = 0; i < SPQ_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_r) && (prio_r[i] >= item_priority);
    end
  end

  for (genvar g = 0; g < SPQ_DEPTH; g++) begin : g_cell
    logic prev_keep;
    logic [DATA_W-1:0]        up_data;
    logic signed [PRIO_W-1:0] up_prio;

    if (g == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign up_data   = item_data;
      assign up_prio   = item_priority;
    end else begin : g_body
      assign prev_keep = keep[g-1];
      assign up_data   = data_r[g-1];
      assign up_prio   = prio_r[g-1];
    end

    always_comb begin
      data_nxt[g] = data_r[g];
      prio_nxt[g] = prio_r[g];
      if (cmd.enq && !keep[g]) begin
        if (prev_keep) begin
          data_nxt[g] = item_data;
          prio_nxt[g] = item_priority;
        end else begin
          data_nxt[g] = up_data;
          prio_nxt[g] = up_prio;
        end
      end else if (cmd.deq && (g < SPQ_DEPTH - 1)) begin
        data_nxt[g] = data_r[(g < SPQ_DEPTH - 1) ? g + 1 : g];
        prio_nxt[g] = prio_r[(g < SPQ_DEPTH - 1) ? g + 1 : g];
      end
    end

    always_ff @(posedge clk) begin
      data_r[g] <= data_nxt[g];
      prio_r[g] <= prio_nxt[g];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_nxt              = rsp_r;
    if (cmd.load) begin
      rsp_nxt.status       = cmd.status;
      rsp_nxt.out_data     = cmd.deq ? data_r[0] : '0;
      rsp_nxt.out_priority = cmd.deq ? prio_r[0] : '0;
      rsp_nxt.entry_count  = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/sorted_priority_queue_top.sv @@
// Sorted priority queue, up to 16 entries of a 32-bit data word and a
// signed 16-bit priority, highest priority at the front.
// Input channel: in_valid / in_stall / in_req. A request is taken when
// in_valid is high and in_stall low. operation 0 inserts the entry behind
// all entries of equal or higher priority; operation 1 removes the front.
// Result channel: out_valid / out_stall / out_rsp. Every request yields one
// result: status (ok, full with the insert dropped, or empty with nothing
// removed), the removed entry (zero unless a dequeue succeeded) and the
// entry count after the request.
// The result is registered: it appears in the output register the cycle
// after acceptance. Throughput is one request per cycle while out_stall is
// low; the whole insert or remove is a parallel shift across the register
// cell chain. When the receiver stalls, the result is held and in_stall
// rises until the result is taken; one request can enter in the cycle the
// result drains. Reset clears the entry count and marks the output register
// empty; the cells keep whatever they hold and are never read until written.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire spq_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output spq_pkg::out_rsp_t      out_rsp
);
  import spq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (in_req.operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_data     (in_req.item_data),
    .item_priority (in_req.item_priority),
    .cmd           (cmd),
    .sts           (sts),
    .rsp           (out_rsp)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.entry_count <= CNT_W'(SPQ_DEPTH)))
    else $error("entry count above depth");

  a_flag_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status != STATUS_OK)) |->
      (out_rsp.out_data == '0 && out_rsp.out_priority == '0))
    else $error("flagged result carries a payload");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == STATUS_FULL)) |->
      (out_rsp.entry_count == CNT_W'(SPQ_DEPTH)))
    else $error("full status below depth");

endmodule
`default_nettype wire
